// File: rtl/core/iplpr_pkg.sv
// shared types and codes of the ipv4 longest prefix route table
`default_nettype none
package iplpr_pkg;

   localparam int MAX_RESULTS = 16;

   typedef enum logic [1:0] {
      REQ_ADD       = 2'd0,
      REQ_DELETE    = 2'd1,
      REQ_UNI_LOOK  = 2'd2,
      REQ_MC_LOOK   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_ROUTE  = 2'd1,
      ST_FULL      = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_ROTATE,
      OP_COMPACT,
      OP_WRITE
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/iplpr_cell.sv
// one route entry cell of the ring: holds, rotates, compacts or is written
`default_nettype none
module iplpr_cell
   import iplpr_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int IDX_BITS   = 1,
   parameter int ENTRY_BITS = 102
) (
   input  wire logic                  clock,
   input  wire cell_op_type           cell_op,
   input  wire logic [IDX_BITS-1:0]   sel_idx,
   input  wire logic [ENTRY_BITS-1:0] next_entry,
   input  wire logic [ENTRY_BITS-1:0] wr_entry,
   output logic      [ENTRY_BITS-1:0] entry
);
   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

   logic [ENTRY_BITS-1:0] entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cell_op)
         OP_ROTATE:  entry_in = next_entry;
         OP_COMPACT: if (MY_IDX >= sel_idx) entry_in = next_entry;
         OP_WRITE:   if (MY_IDX == sel_idx) entry_in = wr_entry;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

// File: rtl/core/ipv4_longest_prefix_route_table.sv
// top level of the ipv4 longest prefix route table
// Routes live in two rings of cells, unicast and multicast, one entry per cell. An add goes
// to the finish step, which writes the entry if well formed and not full, then to the result
// transfer. A delete or lookup rotates both rings once past the head cell, then finishes and
// presents the result; a delete closes the gap in the finish step. A multicast lookup pauses
// the rotation while a match waits for the result channel. One item is in work at a time.
`default_nettype none
module ipv4_longest_prefix_route_table
   import iplpr_pkg::*;
#(
   parameter int UNICAST_DEPTH   = 64,
   parameter int MULTICAST_DEPTH = 16,
   parameter int PORT_BITS       = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_netmask,
   input  wire logic [31:0] req_gateway,
   input  wire logic [5:0]  req_out_port,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_next_hop,
   output logic [5:0]       rsp_port,
   output logic             rsp_last
);
   localparam int EB    = 96 + PORT_BITS;
   localparam int UIB   = (UNICAST_DEPTH > 1) ? $clog2(UNICAST_DEPTH) : 1;
   localparam int MIB   = (MULTICAST_DEPTH > 1) ? $clog2(MULTICAST_DEPTH) : 1;
   localparam int UCB   = $clog2(UNICAST_DEPTH + 1);
   localparam int MCB   = $clog2(MULTICAST_DEPTH + 1);
   localparam int STEPS = (UNICAST_DEPTH > MULTICAST_DEPTH) ? UNICAST_DEPTH : MULTICAST_DEPTH;
   localparam int SB    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CW    = 12;
   localparam int NB    = $clog2(MAX_RESULTS + 1);
   localparam logic [SB-1:0] STEP_LAST = SB'(STEPS - 1);
   localparam logic [UCB-1:0] UNI_FULL = UCB'(UNICAST_DEPTH);
   localparam logic [MCB-1:0] MC_FULL  = MCB'(MULTICAST_DEPTH);
   localparam logic [NB-1:0] N_MAX    = NB'(MAX_RESULTS);

   logic [EB-1:0] uni_q [UNICAST_DEPTH];
   logic [EB-1:0] mc_q  [MULTICAST_DEPTH];
   cell_op_type   uni_op, mc_op;
   logic [UIB-1:0] uni_sel;
   logic [MIB-1:0] mc_sel;
   logic [EB-1:0]  wr_entry;

   state_type      state_ff, state_in;
   logic [1:0]     type_ff, type_in;
   logic [31:0]    addr_ff, addr_in, mask_ff, mask_in, gw_ff, gw_in;
   logic [PORT_BITS-1:0] port_ff, port_in;
   logic [SB-1:0]  step_ff, step_in;
   logic [UCB-1:0] uni_count_ff, uni_count_in;
   logic [MCB-1:0] mc_count_ff, mc_count_in;
   logic           uhit_ff, uhit_in, mhit_ff, mhit_in;
   logic [UIB-1:0] uidx_ff, uidx_in;
   logic [MIB-1:0] midx_ff, midx_in;
   logic           found_ff, found_in;
   logic [31:0]    best_mask_ff, best_mask_in, best_gw_ff, best_gw_in;
   logic [PORT_BITS-1:0] best_port_ff, best_port_in;
   logic           pend_ff, pend_in;
   logic [31:0]    pend_gw_ff, pend_gw_in;
   logic [PORT_BITS-1:0] pend_port_ff, pend_port_in;
   logic [NB-1:0]  nres_ff, nres_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [31:0]    res_hop_ff, res_hop_in;
   logic [PORT_BITS-1:0] res_port_ff, res_port_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_hop_ff, rsp_hop_in;
   logic [5:0]     rsp_port_ff, rsp_port_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [PORT_BITS+5:0] in_port_ext;
   logic [PORT_BITS-1:0] in_port;
   logic [31:0]    u_pre, u_msk, u_gw, m_pre, m_msk, m_gw;
   logic [PORT_BITS-1:0] u_prt, m_prt;
   logic           u_valid, m_valid, u_match, m_match, u_eq, m_eq;
   logic           out_free, emit, emit_last, pause;
   logic [1:0]     emit_status;
   logic [31:0]    emit_hop;
   logic [PORT_BITS-1:0] emit_port;
   logic [PORT_BITS+5:0] emit_port_ext;

   genvar gi;
   generate
      for (gi = 0; gi < UNICAST_DEPTH; gi++) begin : g_uni
         iplpr_cell #(.INDEX(gi), .IDX_BITS(UIB), .ENTRY_BITS(EB)) u_cell (
            .clock      (clock),
            .cell_op    (uni_op),
            .sel_idx    (uni_sel),
            .next_entry (uni_q[(gi + 1) % UNICAST_DEPTH]),
            .wr_entry   (wr_entry),
            .entry      (uni_q[gi])
         );
      end
      for (gi = 0; gi < MULTICAST_DEPTH; gi++) begin : g_mc
         iplpr_cell #(.INDEX(gi), .IDX_BITS(MIB), .ENTRY_BITS(EB)) u_cell (
            .clock      (clock),
            .cell_op    (mc_op),
            .sel_idx    (mc_sel),
            .next_entry (mc_q[(gi + 1) % MULTICAST_DEPTH]),
            .wr_entry   (wr_entry),
            .entry      (mc_q[gi])
         );
      end
   endgenerate

   assign in_port_ext = {{PORT_BITS{1'b0}}, req_out_port};
   assign in_port     = in_port_ext[PORT_BITS-1:0];
   assign wr_entry    = {addr_ff, mask_ff, gw_ff, port_ff};

   assign {u_pre, u_msk, u_gw, u_prt} = uni_q[0];
   assign {m_pre, m_msk, m_gw, m_prt} = mc_q[0];

   assign u_valid = (CW'(step_ff) < CW'(UNICAST_DEPTH)) && (CW'(step_ff) < CW'(uni_count_ff));
   assign m_valid = (CW'(step_ff) < CW'(MULTICAST_DEPTH)) && (CW'(step_ff) < CW'(mc_count_ff));
   assign u_match = (addr_ff & u_msk) == (u_pre & u_msk);
   assign m_match = (addr_ff & m_msk) == (m_pre & m_msk);
   assign u_eq    = (u_pre == addr_ff) && (u_msk == mask_ff) && (u_gw == gw_ff);
   assign m_eq    = (m_pre == addr_ff) && (m_msk == mask_ff) && (m_gw == gw_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      gw_in         = gw_ff;
      port_in       = port_ff;
      step_in       = step_ff;
      uni_count_in  = uni_count_ff;
      mc_count_in   = mc_count_ff;
      uhit_in       = uhit_ff;
      uidx_in       = uidx_ff;
      mhit_in       = mhit_ff;
      midx_in       = midx_ff;
      found_in      = found_ff;
      best_mask_in  = best_mask_ff;
      best_gw_in    = best_gw_ff;
      best_port_in  = best_port_ff;
      pend_in       = pend_ff;
      pend_gw_in    = pend_gw_ff;
      pend_port_in  = pend_port_ff;
      nres_in       = nres_ff;
      res_status_in = res_status_ff;
      res_hop_in    = res_hop_ff;
      res_port_in   = res_port_ff;
      uni_op        = OP_HOLD;
      mc_op         = OP_HOLD;
      uni_sel       = '0;
      mc_sel        = '0;
      emit          = 1'b0;
      emit_status   = ST_OK;
      emit_hop      = '0;
      emit_port     = '0;
      emit_last     = 1'b0;
      pause         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               addr_in  = req_address;
               mask_in  = req_netmask;
               gw_in    = req_gateway;
               port_in  = in_port;
               step_in  = '0;
               uhit_in  = 1'b0;
               mhit_in  = 1'b0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               nres_in  = '0;
               state_in = (req_type == REQ_ADD) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            case (type_ff)
               REQ_DELETE: begin
                  if (u_valid && !uhit_ff && u_eq) begin
                     uhit_in = 1'b1;
                     uidx_in = step_ff[UIB-1:0];
                  end
                  if (m_valid && !mhit_ff && m_eq) begin
                     mhit_in = 1'b1;
                     midx_in = step_ff[MIB-1:0];
                  end
               end
               REQ_UNI_LOOK: begin
                  if (u_valid && u_match && (!found_ff || u_msk > best_mask_ff)) begin
                     found_in     = 1'b1;
                     best_mask_in = u_msk;
                     best_gw_in   = u_gw;
                     best_port_in = u_prt;
                  end
               end
               REQ_MC_LOOK: begin
                  if (m_valid && m_match && nres_ff < N_MAX) begin
                     if (pend_ff && !out_free) begin
                        pause = 1'b1;
                     end else begin
                        if (pend_ff) begin
                           emit      = 1'b1;
                           emit_hop  = pend_gw_ff;
                           emit_port = pend_port_ff;
                        end
                        pend_in      = 1'b1;
                        pend_gw_in   = m_gw;
                        pend_port_in = m_prt;
                        nres_in      = nres_ff + NB'(1);
                     end
                  end
               end
               default: ;
            endcase
            if (!pause) begin
               if (CW'(step_ff) < CW'(UNICAST_DEPTH)) uni_op = OP_ROTATE;
               if (CW'(step_ff) < CW'(MULTICAST_DEPTH)) mc_op = OP_ROTATE;
               if (step_ff == STEP_LAST) state_in = S_DONE;
               else step_in = step_ff + SB'(1);
            end
         end
         S_DONE: begin
            res_hop_in  = '0;
            res_port_in = '0;
            state_in    = S_RESP;
            case (type_ff)
               REQ_ADD: begin
                  if ((addr_ff == 32'd0) != (mask_ff == 32'd0)) begin
                     res_status_in = ST_MALFORMED;
                  end else if (addr_ff[31:28] == 4'hE) begin
                     if (mc_count_ff >= MC_FULL) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mc_op         = OP_WRITE;
                        mc_sel        = mc_count_ff[MIB-1:0];
                        mc_count_in   = mc_count_ff + MCB'(1);
                        res_status_in = ST_OK;
                     end
                  end else begin
                     if (uni_count_ff >= UNI_FULL) begin
                        res_status_in = ST_FULL;
                     end else begin
                        uni_op        = OP_WRITE;
                        uni_sel       = uni_count_ff[UIB-1:0];
                        uni_count_in  = uni_count_ff + UCB'(1);
                        res_status_in = ST_OK;
                     end
                  end
               end
               REQ_DELETE: begin
                  if (uhit_ff) begin
                     uni_op        = OP_COMPACT;
                     uni_sel       = uidx_ff;
                     uni_count_in  = uni_count_ff - UCB'(1);
                     res_status_in = ST_OK;
                  end else if (mhit_ff) begin
                     mc_op         = OP_COMPACT;
                     mc_sel        = midx_ff;
                     mc_count_in   = mc_count_ff - MCB'(1);
                     res_status_in = ST_OK;
                  end else begin
                     res_status_in = ST_NO_ROUTE;
                  end
               end
               REQ_UNI_LOOK: begin
                  res_status_in = found_ff ? ST_OK : ST_NO_ROUTE;
                  if (found_ff) begin
                     res_hop_in  = best_gw_ff;
                     res_port_in = best_port_ff;
                  end
               end
               default: begin
                  res_status_in = pend_ff ? ST_OK : ST_NO_ROUTE;
                  if (pend_ff) begin
                     res_hop_in  = pend_gw_ff;
                     res_port_in = pend_port_ff;
                  end
               end
            endcase
         end
         S_RESP: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = res_status_ff;
               emit_hop    = res_hop_ff;
               emit_port   = res_port_ff;
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign emit_port_ext = {6'd0, emit_port};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_hop_in    = emit_hop;
         rsp_port_in   = emit_port_ext[5:0];
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         uni_count_ff <= '0;
         mc_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uni_count_ff <= uni_count_in;
         mc_count_ff  <= mc_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      addr_ff       <= addr_in;
      mask_ff       <= mask_in;
      gw_ff         <= gw_in;
      port_ff       <= port_in;
      step_ff       <= step_in;
      uhit_ff       <= uhit_in;
      uidx_ff       <= uidx_in;
      mhit_ff       <= mhit_in;
      midx_ff       <= midx_in;
      found_ff      <= found_in;
      best_mask_ff  <= best_mask_in;
      best_gw_ff    <= best_gw_in;
      best_port_ff  <= best_port_in;
      pend_ff       <= pend_in;
      pend_gw_ff    <= pend_gw_in;
      pend_port_ff  <= pend_port_in;
      nres_ff       <= nres_in;
      res_status_ff <= res_status_in;
      res_hop_ff    <= res_hop_in;
      res_port_ff   <= res_port_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_next_hop = rsp_hop_ff;
   assign rsp_port     = rsp_port_ff;
   assign rsp_last     = rsp_last_ff;

   a_uni_count_range: assert property (@(posedge clock) disable iff (reset)
      uni_count_ff <= UNI_FULL)
      else $error("unicast count beyond depth");

   a_mc_count_range: assert property (@(posedge clock) disable iff (reset)
      mc_count_ff <= MC_FULL)
      else $error("multicast count beyond depth");

   a_count_only_in_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(uni_count_ff) && $stable(mc_count_ff))
      else $error("table count changed outside finish step");

   a_resp_leaves_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && out_free) |=> rsp_valid_ff && rsp_last_ff && state_ff == S_IDLE)
      else $error("final result transfer lost");
endmodule
`default_nettype wire
